// ===== hw/rtl/calendar_date_adder_assert.svh =====
// ----------------------------------------------------------------------------
// calendar_date_adder_assert
// Assertion macros for the date adder. Both sample on i_clk and are
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ADDER_ASSERT_SVH
`define CALENDAR_DATE_ADDER_ASSERT_SVH

// Same-cycle implication.
`define CDA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg
// Shared constants, controller/datapath link types and calendar helpers.
// ----------------------------------------------------------------------------
package cda_pkg;

    localparam logic [2:0] OP_DAYS     = 3'd0;
    localparam logic [2:0] OP_WEEKS    = 3'd1;
    localparam logic [2:0] OP_MONTHS   = 3'd2;
    localparam logic [2:0] OP_YR_STEP  = 3'd3;
    localparam logic [2:0] OP_YR_DIR   = 3'd4;
    localparam logic [2:0] OP_DEC_STEP = 3'd5;
    localparam logic [2:0] OP_DEC_DIR  = 3'd6;
    localparam logic [2:0] OP_UNUSED   = 3'd7;

    localparam logic [13:0] YEAR_MAX     = 14'd9999;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [3:0]  MONTH_DEC    = 4'd12;
    localparam logic [4:0]  DAY_FEB_LEAP = 5'd29;
    localparam logic [4:0]  DAY_FEB      = 5'd28;

    // floor(y / 100) == (y * DIV100_MUL) >> DIV100_SHIFT for y < 43690
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic load;
        logic fail;
        logic step;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic chk_bad;
        logic fin;
    } t_dp_sts;

    function automatic logic is_leap(input logic [13:0] y);
        logic [26:0] prod;
        logic [7:0]  q;
        logic [13:0] hund;
        begin
            prod = 27'(y) * 27'(DIV100_MUL);
            q    = prod[DIV100_SHIFT +: 8];
            hund = 14'(14'(q) * 14'd100);
            if (hund == y) begin
                is_leap = (q[1:0] == 2'd0);
            end else begin
                is_leap = (y[1:0] == 2'd0);
            end
        end
    endfunction

    function automatic logic [4:0] month_days(input logic [13:0] y, input logic [3:0] m);
        logic [3:0] idx;
        begin
            idx = m - 4'd1;
            if (!(m inside {[4'd1:4'd12]})) begin
                month_days = 5'd0;
            end else if (m == MONTH_FEB) begin
                month_days = is_leap(y) ? DAY_FEB_LEAP : DAY_FEB;
            end else begin
                month_days = MONTH_LEN[idx];
            end
        end
    endfunction

endpackage

// ===== hw/rtl/calendar_date_adder.sv =====
// ----------------------------------------------------------------------------
// calendar_date_adder
// Moves a Gregorian date forward by days, weeks, months, years or decades.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  input    in         i_in_valid / o_in_stall   i_opcode i_amount i_day_in
//                                                i_month_in i_year_in
//  output   out        o_out_valid / i_out_stall o_day_out o_month_out
//                                                o_year_out o_error_flag
//
// One item at a time: accept, check, the step cycles, then hand-off. Steps:
// one per month crossed plus one, one fewer on year overflow (days, weeks);
// one per unit, at least one (months; stepwise years/decades, ending at year
// overflow); one (direct). Worst case is months with amount 65535; invalid
// dates skip the step loop. The next item is accepted while a result waits
// on a stall. Reset is synchronous, active low, clears only control state.
// ----------------------------------------------------------------------------
module calendar_date_adder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [15:0] i_amount,
    input  logic [4:0]  i_day_in,
    input  logic [3:0]  i_month_in,
    input  logic [13:0] i_year_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_day_out,
    output logic [3:0]  o_month_out,
    output logic [13:0] o_year_out,
    output logic        o_error_flag
);

    cda_pkg::t_dp_cmd cmd;
    cda_pkg::t_dp_sts sts;

    cda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cda_dpath u_dpath (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_opcode     (i_opcode),
        .i_amount     (i_amount),
        .i_day_in     (i_day_in),
        .i_month_in   (i_month_in),
        .i_year_in    (i_year_in),
        .o_day_out    (o_day_out),
        .o_month_out  (o_month_out),
        .o_year_out   (o_year_out),
        .o_error_flag (o_error_flag)
    );

endmodule

// ===== hw/rtl/cda_dpath.sv =====
// ----------------------------------------------------------------------------
// cda_dpath
// Date registers, one step of day/month/year advance per command, result regs.
// ----------------------------------------------------------------------------
module cda_dpath (
    input  logic             i_clk,
    input  cda_pkg::t_dp_cmd i_cmd,
    output cda_pkg::t_dp_sts o_sts,
    input  logic [2:0]       i_opcode,
    input  logic [15:0]      i_amount,
    input  logic [4:0]       i_day_in,
    input  logic [3:0]       i_month_in,
    input  logic [13:0]      i_year_in,
    output logic [4:0]       o_day_out,
    output logic [3:0]       o_month_out,
    output logic [13:0]      o_year_out,
    output logic             o_error_flag
);

    logic [2:0]  r_op;
    logic [19:0] r_n;
    logic [4:0]  r_d, r_d0;
    logic [3:0]  r_m, r_m0;
    logic [13:0] r_y, r_y0;
    logic        r_err;
    logic [4:0]  r_do;
    logic [3:0]  r_mo;
    logic [13:0] r_yo;
    logic        r_eo;

    logic [19:0] c_n_load;
    logic [4:0]  c_dim;
    logic [4:0]  c_left;
    logic [3:0]  c_nm;
    logic [4:0]  c_nm_len;
    logic        c_dec;
    logic [13:0] c_yinc;
    logic [13:0] c_ys;
    logic [20:0] c_yd;
    logic        c_feb29;
    logic [4:0]  n_d;
    logic [3:0]  n_m;
    logic [13:0] n_y;
    logic [19:0] n_n;
    logic        s_fin;
    logic        s_ovf;

    always_comb begin
        case (i_opcode)
            cda_pkg::OP_WEEKS:   c_n_load = (20'(i_amount) << 3) - 20'(i_amount);
            cda_pkg::OP_DEC_DIR: c_n_load = (20'(i_amount) << 3) + (20'(i_amount) << 1);
            default:             c_n_load = 20'(i_amount);
        endcase
    end

    assign c_dim    = cda_pkg::month_days(r_y, r_m);
    assign c_left   = c_dim - r_d;
    assign c_dec    = (r_m == cda_pkg::MONTH_DEC);
    assign c_nm     = c_dec ? 4'd1 : r_m + 4'd1;
    assign c_nm_len = cda_pkg::month_days(r_y, c_nm);
    assign c_yinc   = r_y + 14'd1;
    assign c_ys     = r_y + ((r_op == cda_pkg::OP_DEC_STEP) ? 14'd10 : 14'd1);
    assign c_yd     = 21'(r_y) + 21'(r_n);
    assign c_feb29  = (r_m == cda_pkg::MONTH_FEB) && (r_d == cda_pkg::DAY_FEB_LEAP);

    assign o_sts.chk_bad = !(r_m inside {[4'd1:4'd12]}) || (r_y == 14'd0)
                           || (r_y > cda_pkg::YEAR_MAX) || (r_d == 5'd0) || (r_d > c_dim)
                           || (r_op == cda_pkg::OP_UNUSED);
    assign o_sts.fin = s_fin;

    always_comb begin
        n_d   = r_d;
        n_m   = r_m;
        n_y   = r_y;
        n_n   = r_n;
        s_fin = 1'b0;
        s_ovf = 1'b0;
        case (r_op)
            cda_pkg::OP_DAYS, cda_pkg::OP_WEEKS: begin
                if (r_n <= 20'(c_left)) begin
                    n_d   = r_d + 5'(r_n);
                    s_fin = 1'b1;
                end else begin
                    n_n = r_n - 20'(c_left) - 20'd1;
                    n_d = 5'd1;
                    n_m = c_nm;
                    if (c_dec) begin
                        n_y = c_yinc;
                        if (c_yinc > cda_pkg::YEAR_MAX) begin
                            s_ovf = 1'b1;
                            s_fin = 1'b1;
                        end
                    end
                end
            end
            cda_pkg::OP_MONTHS: begin
                if (r_n == 20'd0) begin
                    s_fin = 1'b1;
                end else begin
                    n_n = r_n - 20'd1;
                    n_m = c_nm;
                    if (c_dec) begin
                        n_y = c_yinc;
                        s_ovf = (c_yinc > cda_pkg::YEAR_MAX);
                    end
                    if (r_d > c_nm_len) begin
                        n_d = c_nm_len;
                    end
                    s_fin = (r_n == 20'd1) || s_ovf;
                end
            end
            cda_pkg::OP_YR_STEP, cda_pkg::OP_DEC_STEP: begin
                if (r_n == 20'd0) begin
                    s_fin = 1'b1;
                end else begin
                    n_n = r_n - 20'd1;
                    n_y = c_ys;
                    if (c_ys > cda_pkg::YEAR_MAX) begin
                        s_ovf = 1'b1;
                    end else if (c_feb29 && !cda_pkg::is_leap(c_ys)) begin
                        n_d = cda_pkg::DAY_FEB;
                    end
                    s_fin = (r_n == 20'd1) || s_ovf;
                end
            end
            cda_pkg::OP_YR_DIR, cda_pkg::OP_DEC_DIR: begin
                s_fin = 1'b1;
                if (c_yd > 21'(cda_pkg::YEAR_MAX)) begin
                    s_ovf = 1'b1;
                end else begin
                    n_y = c_yd[13:0];
                    if (c_feb29 && !cda_pkg::is_leap(c_yd[13:0])) begin
                        n_d = cda_pkg::DAY_FEB;
                    end
                end
            end
            default: begin
                s_fin = 1'b1;
                s_ovf = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_n   <= c_n_load;
            r_d   <= i_day_in;
            r_m   <= i_month_in;
            r_y   <= i_year_in;
            r_d0  <= i_day_in;
            r_m0  <= i_month_in;
            r_y0  <= i_year_in;
            r_err <= 1'b0;
        end else if (i_cmd.fail) begin
            r_err <= 1'b1;
        end else if (i_cmd.step) begin
            r_d <= n_d;
            r_m <= n_m;
            r_y <= n_y;
            r_n <= n_n;
            if (s_ovf) begin
                r_err <= 1'b1;
            end
        end
        if (i_cmd.publish) begin
            r_do <= r_err ? r_d0 : r_d;
            r_mo <= r_err ? r_m0 : r_m;
            r_yo <= r_err ? r_y0 : r_y;
            r_eo <= r_err;
        end
    end

    assign o_day_out    = r_do;
    assign o_month_out  = r_mo;
    assign o_year_out   = r_yo;
    assign o_error_flag = r_eo;

endmodule

// ===== hw/rtl/cda_ctrl.sv =====
// ----------------------------------------------------------------------------
// cda_ctrl
// Sequencer: accept, validity check, step loop, hand-off to the output reg.
// ----------------------------------------------------------------------------
`include "calendar_date_adder_assert.svh"

module cda_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  cda_pkg::t_dp_sts i_sts,
    output cda_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;
    localparam logic [1:0] S_HOLD  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       c_out_free;

    assign c_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.chk_bad) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_HOLD;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.fin) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (c_out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `CDA_ASSERT_NEXT(a_accept_to_check, i_in_valid && !o_in_stall, r_state == S_CHECK,
        "accepted item did not enter check")
    `CDA_ASSERT_NOW(a_publish_free, o_cmd.publish, !r_out_valid || !i_out_stall,
        "result published over a pending item")
    `CDA_ASSERT_NEXT(a_bad_to_hold, r_state == S_CHECK && i_sts.chk_bad, r_state == S_HOLD,
        "invalid item did not go straight to hold")
    `CDA_ASSERT_NEXT(a_fin_to_hold, r_state == S_RUN && i_sts.fin, r_state == S_HOLD,
        "finished step loop did not go to hold")

endmodule

// ===== test/calendar_date_adder_test.sv =====
// ----------------------------------------------------------------------------
// calendar_date_adder_test
// Drives dated items through calendar_date_adder and checks each result field
// by field. A short table covers the opcodes, the field extremes, bad dates,
// leap-day handling and year overflow. Random items follow, mostly valid dates
// with some malformed ones. Both sides idle in short random bursts, except in
// the final stretch.
// ----------------------------------------------------------------------------
module calendar_date_adder_test;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] amount;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } t_date_req;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        err;
    } t_date_res;

    typedef struct packed {
        logic      typed;
        t_date_res res;
    } t_item_note;

    typedef struct packed {
        t_date_req  req;
        t_item_note note;
    } t_table_row;

    localparam int N_RANDOM = 115;
    localparam int N_TAIL   = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_opcode;
    logic [15:0] i_amount;
    logic [4:0]  i_day_in;
    logic [3:0]  i_month_in;
    logic [13:0] i_year_in;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [4:0]  o_day_out;
    logic [3:0]  o_month_out;
    logic [13:0] o_year_out;
    logic        o_error_flag;

    t_date_res  dates_due [$];
    t_item_note item_notes [$];
    int         n_mismatch = 0;
    bit         quiet_tail = 1'b0;

    calendar_date_adder i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_amount     (i_amount),
        .i_day_in     (i_day_in),
        .i_month_in   (i_month_in),
        .i_year_in    (i_year_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_day_out    (o_day_out),
        .o_month_out  (o_month_out),
        .o_year_out   (o_year_out),
        .o_error_flag (o_error_flag)
    );

    function automatic bit is_leap_year(input int y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int days_in(input int y, input int m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic t_date_res shift_date(input t_date_req r);
        int        d, m, y, n, left, i, ml, unit;
        bit        ok;
        t_date_res res;
        d  = r.day;
        m  = r.month;
        y  = r.year;
        ok = (m >= 1 && m <= 12 && y >= 1 && y <= int'(cda_pkg::YEAR_MAX) &&
              d >= 1 && d <= days_in(y, m));
        if (ok) begin
            case (r.op)
                cda_pkg::OP_DAYS, cda_pkg::OP_WEEKS: begin
                    n = (r.op == cda_pkg::OP_WEEKS) ? int'(r.amount) * 7 : int'(r.amount);
                    while (ok && n > 0) begin
                        left = days_in(y, m) - d;
                        if (n <= left) begin
                            d = d + n;
                            n = 0;
                        end else begin
                            n = n - (left + 1);
                            d = 1;
                            if (m == cda_pkg::MONTH_DEC) begin
                                m = 1;
                                y = y + 1;
                                if (y > cda_pkg::YEAR_MAX) ok = 1'b0;
                            end else begin
                                m = m + 1;
                            end
                        end
                    end
                end
                cda_pkg::OP_MONTHS: begin
                    for (i = 0; ok && i < r.amount; i++) begin
                        if (m == cda_pkg::MONTH_DEC) begin
                            m = 1;
                            y = y + 1;
                            if (y > cda_pkg::YEAR_MAX) ok = 1'b0;
                        end else begin
                            m = m + 1;
                        end
                        ml = days_in(y, m);
                        if (d > ml) d = ml;
                    end
                end
                cda_pkg::OP_YR_STEP, cda_pkg::OP_DEC_STEP: begin
                    unit = (r.op == cda_pkg::OP_DEC_STEP) ? 10 : 1;
                    for (i = 0; ok && i < r.amount; i++) begin
                        y = y + unit;
                        if (y > cda_pkg::YEAR_MAX) begin
                            ok = 1'b0;
                        end else if (m == cda_pkg::MONTH_FEB && d == cda_pkg::DAY_FEB_LEAP
                                     && !is_leap_year(y)) begin
                            d = cda_pkg::DAY_FEB;
                        end
                    end
                end
                cda_pkg::OP_YR_DIR, cda_pkg::OP_DEC_DIR: begin
                    y = y + int'(r.amount) * ((r.op == cda_pkg::OP_DEC_DIR) ? 10 : 1);
                    if (y > cda_pkg::YEAR_MAX) begin
                        ok = 1'b0;
                    end else if (m == cda_pkg::MONTH_FEB && d == cda_pkg::DAY_FEB_LEAP
                                 && !is_leap_year(y)) begin
                        d = cda_pkg::DAY_FEB;
                    end
                end
                default: ok = 1'b0;
            endcase
        end
        if (ok) begin
            res.day   = 5'(d);
            res.month = 4'(m);
            res.year  = 14'(y);
            res.err   = 1'b0;
        end else begin
            res.day   = r.day;
            res.month = r.month;
            res.year  = r.year;
            res.err   = 1'b1;
        end
        return res;
    endfunction

    function automatic t_table_row table_row(
        input logic [2:0] op, input int amt, input int d, input int m, input int y,
        input bit typed, input int ed, input int em, input int ey, input bit ee
    );
        t_table_row r;
        r.req            = '{op, 16'(amt), 5'(d), 4'(m), 14'(y)};
        r.note.typed     = typed;
        r.note.res       = '{5'(ed), 4'(em), 14'(ey), ee};
        return r;
    endfunction

    // one item per call, entered and left at a falling edge
    task automatic send_item(input t_date_req req, input t_item_note note);
        int gap;
        if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 3);
            repeat (gap) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        item_notes.push_back(note);
        i_in_valid <= 1'b1;
        i_opcode   <= req.op;
        i_amount   <= req.amount;
        i_day_in   <= req.day;
        i_month_in <= req.month;
        i_year_in  <= req.year;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : out_side
        int hold;
        hold        = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet_tail) begin
                hold = 0;
                i_out_stall <= 1'b0;
            end else if (hold > 0) begin
                hold = hold - 1;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                hold = $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_date_res  got, want;
        t_item_note note;
        t_date_req  req;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_day_out, o_month_out, o_year_out, o_error_flag};
                if (dates_due.size() == 0) begin
                    $error("result with no item pending: %0d/%0d/%0d err %0d",
                           got.day, got.month, got.year, got.err);
                    n_mismatch++;
                end else begin
                    want = dates_due.pop_front();
                    if (got.day !== want.day) begin
                        $error("day_out: expected %0d, actual %0d", want.day, got.day);
                        n_mismatch++;
                    end
                    if (got.month !== want.month) begin
                        $error("month_out: expected %0d, actual %0d", want.month, got.month);
                        n_mismatch++;
                    end
                    if (got.year !== want.year) begin
                        $error("year_out: expected %0d, actual %0d", want.year, got.year);
                        n_mismatch++;
                    end
                    if (got.err !== want.err) begin
                        $error("error_flag: expected %0d, actual %0d", want.err, got.err);
                        n_mismatch++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                note = item_notes.pop_front();
                req  = '{i_opcode, i_amount, i_day_in, i_month_in, i_year_in};
                dates_due.push_back(note.typed ? note.res : shift_date(req));
            end
        end
    end

    initial begin : stimulus
        t_table_row rows [$];
        t_date_req  req;
        t_item_note note;
        int         k, d, m, y, ml, big_left;
        logic [2:0] op;
        logic [15:0] amt;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_opcode   = cda_pkg::OP_DAYS;
        i_amount   = '0;
        i_day_in   = '0;
        i_month_in = '0;
        i_year_in  = '0;
        big_left   = 5;

        //                       op                    amount d   m   y      typed expected
        rows.push_back(table_row(cda_pkg::OP_DAYS,     0,     1,  1,  1,     1, 1,  1,  1,     0));
        rows.push_back(table_row(cda_pkg::OP_DAYS,     1,     31, 12, 9999,  1, 31, 12, 9999,  1));
        rows.push_back(table_row(cda_pkg::OP_DAYS,     65535, 1,  1,  1,     0, 0,  0,  0,     0));
        rows.push_back(table_row(cda_pkg::OP_WEEKS,    65535, 15, 6,  2024,  0, 0,  0,  0,     0));
        rows.push_back(table_row(cda_pkg::OP_MONTHS,   65535, 31, 1,  1,     0, 0,  0,  0,     0));
        rows.push_back(table_row(cda_pkg::OP_MONTHS,   1,     31, 1,  2024,  0, 0,  0,  0,     0));
        rows.push_back(table_row(cda_pkg::OP_MONTHS,   1,     31, 1,  2023,  0, 0,  0,  0,     0));
        rows.push_back(table_row(cda_pkg::OP_MONTHS,   1,     15, 12, 9999,  1, 15, 12, 9999,  1));
        rows.push_back(table_row(cda_pkg::OP_YR_STEP,  1,     29, 2,  2024,  0, 0,  0,  0,     0));
        rows.push_back(table_row(cda_pkg::OP_YR_STEP,  4,     29, 2,  2024,  0, 0,  0,  0,     0));
        rows.push_back(table_row(cda_pkg::OP_YR_DIR,   4,     29, 2,  2024,  0, 0,  0,  0,     0));
        rows.push_back(table_row(cda_pkg::OP_YR_DIR,   65535, 1,  1,  1,     1, 1,  1,  1,     1));
        rows.push_back(table_row(cda_pkg::OP_DEC_STEP, 10,    29, 2,  1996,  0, 0,  0,  0,     0));
        rows.push_back(table_row(cda_pkg::OP_DEC_DIR,  40,    29, 2,  1600,  0, 0,  0,  0,     0));
        rows.push_back(table_row(cda_pkg::OP_DEC_STEP, 65535, 5,  5,  5,     1, 5,  5,  5,     1));
        rows.push_back(table_row(cda_pkg::OP_DEC_DIR,  999,   1,  1,  9,     0, 0,  0,  0,     0));
        rows.push_back(table_row(cda_pkg::OP_UNUSED,   1,     10, 10, 2000,  1, 10, 10, 2000,  1));
        rows.push_back(table_row(cda_pkg::OP_DAYS,     1,     0,  1,  2000,  1, 0,  1,  2000,  1));
        rows.push_back(table_row(cda_pkg::OP_DAYS,     1,     31, 15, 16383, 1, 31, 15, 16383, 1));
        rows.push_back(table_row(cda_pkg::OP_MONTHS,   1,     1,  0,  2000,  1, 1,  0,  2000,  1));
        rows.push_back(table_row(cda_pkg::OP_YR_STEP,  1,     1,  1,  0,     1, 1,  1,  0,     1));
        rows.push_back(table_row(cda_pkg::OP_DAYS,     1,     29, 2,  1900,  1, 29, 2,  1900,  1));
        rows.push_back(table_row(cda_pkg::OP_DAYS,     1,     29, 2,  2000,  0, 0,  0,  0,     0));
        rows.push_back(table_row(cda_pkg::OP_YR_DIR,   0,     1,  1,  10000, 1, 1,  1,  10000, 1));
        rows.push_back(table_row(cda_pkg::OP_DAYS,     1,     31, 12, 9998,  0, 0,  0,  0,     0));

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) send_item(rows[k].req, rows[k].note);

        note = '0;
        for (k = 0; k < N_RANDOM; k++) begin
            if (k >= N_RANDOM - N_TAIL) quiet_tail = 1'b1;
            case ($urandom_range(0, 5))
                0:       y = $urandom_range(1, 20);
                1:       y = $urandom_range(9980, 9999);
                2:       y = 100 * $urandom_range(15, 25);
                3:       y = 4 * $urandom_range(1, 2499);
                default: y = $urandom_range(1, 9999);
            endcase
            m  = $urandom_range(1, 12);
            ml = days_in(y, m);
            d  = ($urandom_range(0, 3) == 0) ? ml : $urandom_range(1, ml);
            op = 3'($urandom_range(0, 6));
            case (op)
                cda_pkg::OP_DAYS:     amt = 16'($urandom_range(0, 1200));
                cda_pkg::OP_WEEKS:    amt = 16'($urandom_range(0, 150));
                cda_pkg::OP_MONTHS:   amt = 16'($urandom_range(0, 200));
                cda_pkg::OP_YR_STEP:  amt = 16'($urandom_range(0, 300));
                cda_pkg::OP_DEC_STEP: amt = 16'(($urandom_range(0, 3) == 0)
                                                ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 100));
                default:              amt = 16'(($urandom_range(0, 3) == 0)
                                                ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 2000));
            endcase
            // rare long runs
            if (op <= cda_pkg::OP_YR_STEP && big_left > 0 && $urandom_range(0, 24) == 0) begin
                amt      = 16'($urandom_range(0, 65535));
                big_left = big_left - 1;
            end
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    op  = 3'($urandom_range(0, 7));
                    amt = 16'($urandom_range(0, 300));
                    d   = $urandom_range(0, 31);
                    m   = $urandom_range(0, 15);
                    y   = $urandom_range(0, 16383);
                end else if (ml < 31) begin
                    d = ml + 1;
                end else begin
                    m = 13;
                end
            end
            req = '{op, amt, 5'(d), 4'(m), 14'(y)};
            send_item(req, note);
        end
        i_in_valid <= 1'b0;

        while (dates_due.size() != 0 || item_notes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_mismatch == 0 && dates_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cda_pkg.sv
hw/rtl/cda_dpath.sv
hw/rtl/cda_ctrl.sv
hw/rtl/calendar_date_adder.sv
test/calendar_date_adder_test.sv
